[design/assert_macros.svh]
// Assertion macros used by the converter's result queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that forces a result in the next one.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/cab_pkg.sv]
// Types and constants of the CIGAR to alignment block converter.
`timescale 1ns / 1ps
`default_nettype none

package cab_pkg;

	localparam int QueueDepth = 4;

	localparam logic [3:0] OP_MATCH = 4'd0;
	localparam logic [3:0] OP_INS   = 4'd1;
	localparam logic [3:0] OP_DEL   = 4'd2;
	localparam logic [3:0] OP_SKIP  = 4'd3;
	localparam logic [3:0] OP_SOFT  = 4'd4;

	localparam logic [2:0] ST_BLOCK   = 3'd0;
	localparam logic [2:0] ST_NOBLOCK = 3'd1;
	localparam logic [2:0] ST_BAD_DEL = 3'd2;
	localparam logic [2:0] ST_BAD_INS = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;

	localparam logic [1:0] MERGE_NONE = 2'd0;
	localparam logic [1:0] MERGE_DEL  = 2'd1;
	localparam logic [1:0] MERGE_INS  = 2'd2;

	typedef struct packed {
		logic [3:0]  op_code;
		logic [27:0] op_length;
		logic [31:0] read_start;
		logic        first_op;
		logic        last_op;
	} cigar_op_t;

	typedef struct packed {
		logic        block_kind;
		logic [31:0] block_start;
		logic [31:0] block_length;
		logic [2:0]  status;
		logic        last_of_read;
	} block_t;

	// One queue entry carries the results of one request, one or two of them.
	typedef struct packed {
		logic   two;
		block_t r0;
		block_t r1;
	} qent_t;

endpackage

`default_nettype wire

[design/cab_front.sv]
// Front end: accepts CIGAR ops, tracks read state and forms the results of each op.
`timescale 1ns / 1ps
`default_nettype none

module cab_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cig_valid,
	output logic                  cig_stall,
	input  wire cab_pkg::cigar_op_t cig,
	input  wire logic             q_full,
	output logic                  q_push,
	output cab_pkg::qent_t        q_data
);

	logic        held_valid_q;
	logic        held_kind_q;
	logic [31:0] held_start_q;
	logic [31:0] held_length_q;
	logic [31:0] ref_q;
	logic [31:0] diff_q;
	logic        prev_match_q;
	logic [1:0]  merge_q;
	logic        discard_q;

	logic        hv_n, kind_n, pm_n, disc_n;
	logic [31:0] start_n, hlen_n, ref_n, diff_n;
	logic [1:0]  merge_n;
	logic        accept;
	logic        open_blk, pre, fin;
	logic [2:0]  err;
	logic [31:0] ref_eff, ref_sum, diff_sum;
	cab_pkg::block_t held_res, fin_res;

	assign cig_stall = q_full;
	assign accept    = cig_valid && !q_full;

	assign ref_eff  = cig.first_op ? cig.read_start : ref_q;
	assign ref_sum  = ref_eff + {4'b0, cig.op_length};
	// diff_q tracks the running offset minus the held block's start.
	assign diff_sum = diff_q + {4'b0, cig.op_length};

	always_comb begin
		hv_n     = cig.first_op ? 1'b0 : held_valid_q;
		pm_n     = cig.first_op ? 1'b0 : prev_match_q;
		merge_n  = cig.first_op ? cab_pkg::MERGE_NONE : merge_q;
		disc_n   = cig.first_op ? 1'b0 : discard_q;
		kind_n   = held_kind_q;
		start_n  = held_start_q;
		hlen_n   = held_length_q;
		ref_n    = ref_eff;
		diff_n   = diff_q;
		err      = cab_pkg::ST_BLOCK;
		open_blk = 1'b0;
		if (!disc_n) begin
			if (merge_n != cab_pkg::MERGE_NONE) begin
				if (cig.op_code == cab_pkg::OP_MATCH) begin
					ref_n   = ref_sum;
					hlen_n  = diff_sum;
					diff_n  = diff_sum;
					merge_n = cab_pkg::MERGE_NONE;
					pm_n    = 1'b1;
				end else begin
					err = (merge_n == cab_pkg::MERGE_DEL) ? cab_pkg::ST_BAD_DEL
						: cab_pkg::ST_BAD_INS;
				end
			end else begin
				case (cig.op_code)
					cab_pkg::OP_MATCH, cab_pkg::OP_SKIP: begin
						open_blk = 1'b1;
						hv_n     = 1'b1;
						kind_n   = (cig.op_code == cab_pkg::OP_SKIP);
						start_n  = ref_eff;
						hlen_n   = {4'b0, cig.op_length};
						diff_n   = {4'b0, cig.op_length};
						ref_n    = ref_sum;
						pm_n     = (cig.op_code == cab_pkg::OP_MATCH);
					end
					cab_pkg::OP_INS, cab_pkg::OP_DEL: begin
						if (!pm_n || cig.last_op) begin
							err = (cig.op_code == cab_pkg::OP_DEL) ? cab_pkg::ST_BAD_DEL
								: cab_pkg::ST_BAD_INS;
						end else begin
							if (cig.op_code == cab_pkg::OP_DEL) begin
								ref_n  = ref_sum;
								diff_n = diff_sum;
							end
							merge_n = (cig.op_code == cab_pkg::OP_DEL) ? cab_pkg::MERGE_DEL
								: cab_pkg::MERGE_INS;
							pm_n = 1'b0;
						end
					end
					cab_pkg::OP_SOFT: begin
						pm_n = 1'b0;
					end
					default: begin
						err = cab_pkg::ST_UNKNOWN;
					end
				endcase
			end
		end

		// The block held before this op goes out first when a new block opens or on an error.
		held_res = '{block_kind: held_kind_q, block_start: held_start_q,
			block_length: held_length_q, status: cab_pkg::ST_BLOCK, last_of_read: 1'b0};
		pre = !disc_n && !cig.first_op && held_valid_q
			&& (open_blk || err != cab_pkg::ST_BLOCK);
		fin = !disc_n && (err != cab_pkg::ST_BLOCK || cig.last_op);
		if (err != cab_pkg::ST_BLOCK) begin
			fin_res = '{block_kind: 1'b0, block_start: 32'd0, block_length: 32'd0,
				status: err, last_of_read: 1'b1};
		end else if (hv_n) begin
			fin_res = '{block_kind: kind_n, block_start: start_n, block_length: hlen_n,
				status: cab_pkg::ST_BLOCK, last_of_read: 1'b1};
		end else begin
			fin_res = '{block_kind: 1'b0, block_start: 32'd0, block_length: 32'd0,
				status: cab_pkg::ST_NOBLOCK, last_of_read: 1'b1};
		end
		if (fin) begin
			hv_n    = 1'b0;
			pm_n    = 1'b0;
			merge_n = cab_pkg::MERGE_NONE;
			disc_n  = (err != cab_pkg::ST_BLOCK);
		end

		q_push = accept && (pre || fin);
		if (pre) begin
			q_data = '{two: fin, r0: held_res, r1: fin_res};
		end else begin
			q_data = '{two: 1'b0, r0: fin_res, r1: fin_res};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			prev_match_q <= 1'b0;
			merge_q      <= cab_pkg::MERGE_NONE;
			discard_q    <= 1'b0;
			ref_q        <= 32'd0;
		end else if (accept) begin
			held_valid_q <= hv_n;
			prev_match_q <= pm_n;
			merge_q      <= merge_n;
			discard_q    <= disc_n;
			ref_q        <= ref_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_kind_q   <= kind_n;
			held_start_q  <= start_n;
			held_length_q <= hlen_n;
			diff_q        <= diff_n;
		end
	end

endmodule

`default_nettype wire

[design/cab_queue.sv]
// Short queue of result entries between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cab_queue #(
	parameter int Depth = cab_pkg::QueueDepth
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire cab_pkg::qent_t wdata,
	output logic                full,
	input  wire logic           pop,
	output cab_pkg::qent_t      rdata,
	output logic                empty
);

	localparam int AW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);

	cab_pkg::qent_t mem_q [Depth];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CW'(Depth));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(Depth), "queue count beyond depth")
	`ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "push lost")
	`ASSERT_NEXT(a_count_down, clk, arst_n, pop && !push, count_q == $past(count_q) - 1'b1, "pop lost")

endmodule

`default_nettype wire

[design/cab_back.sv]
// Output stage: takes queue entries and sends their results one per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module cab_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire cab_pkg::qent_t q_head,
	output logic                q_pop,
	output logic                blk_valid,
	input  wire logic           blk_stall,
	output cab_pkg::block_t     blk
);

	logic            blk_valid_q;
	cab_pkg::block_t blk_q;
	logic            pend_valid_q;
	cab_pkg::block_t pend_q;
	logic            load;

	assign load      = !blk_valid_q || !blk_stall;
	assign q_pop     = load && !pend_valid_q && !q_empty;
	assign blk_valid = blk_valid_q;
	assign blk       = blk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				blk_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				blk_valid_q  <= !q_empty;
				pend_valid_q <= !q_empty && q_head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				blk_q <= pend_q;
			end else if (!q_empty) begin
				blk_q  <= q_head.r0;
				pend_q <= q_head.r1;
			end
		end
	end

endmodule

`default_nettype wire

[design/cigar_to_aligned_blocks.sv]
// A result is written into the result queue when its CIGAR op is accepted, then registered in the output stage.
// Throughput: one op per cycle at the input while the queue is not full; results leave one per cycle unless stalled.
// An op that yields two results sends them one after the other; the result queue holds QUEUE_DEPTH entries.
// Input stalls only while the result queue is full, after output stalls or two-result runs.
// Reset clears read state, running offset and queue at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module cigar_to_aligned_blocks #(
	parameter int QUEUE_DEPTH = cab_pkg::QueueDepth
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cig_valid,
	output logic                    cig_stall,
	input  wire cab_pkg::cigar_op_t cig,
	output logic                    blk_valid,
	input  wire logic               blk_stall,
	output cab_pkg::block_t         blk
);

	logic           q_full, q_push, q_pop, q_empty;
	cab_pkg::qent_t q_wdata, q_rdata;

	cab_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cig_valid (cig_valid),
		.cig_stall (cig_stall),
		.cig       (cig),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	cab_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	cab_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_rdata),
		.q_pop     (q_pop),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.blk       (blk)
	);

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the CIGAR to alignment block converter.
`timescale 1ns / 1ps

module tb;

	localparam logic KIND_EXON   = 1'b0;
	localparam logic KIND_INTRON = 1'b1;

	localparam logic [3:0] OP_UNKNOWN_LO = 4'd5;
	localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cig_valid = 1'b0;
	logic               cig_stall;
	cab_pkg::cigar_op_t cig = '0;
	logic               blk_valid;
	logic               blk_stall = 1'b0;
	cab_pkg::block_t    blk;

	int idle_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int live_ops = 0;

	cab_pkg::block_t pending_blocks[$];

	// Shadow of the converter's read state.
	logic        open_valid;
	logic        open_kind;
	logic [31:0] open_start;
	logic [31:0] open_length;
	logic [31:0] ref_cursor;
	logic        after_match;
	logic [1:0]  merge_wait;
	logic        skipping_read;

	cigar_to_aligned_blocks i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cig_valid (cig_valid),
		.cig_stall (cig_stall),
		.cig       (cig),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.blk       (blk)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 50) begin
			$display("%0t mismatch: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
		end
	endtask

	function automatic void expect_block(input logic kind, input logic [31:0] start,
		input logic [31:0] length, input logic [2:0] status, input logic last);
		cab_pkg::block_t b;
		b.block_kind = kind;
		b.block_start = start;
		b.block_length = length;
		b.status = status;
		b.last_of_read = last;
		pending_blocks = {pending_blocks, b};
	endfunction

	function automatic void abandon_read();
		open_valid = 1'b0;
		open_kind = KIND_EXON;
		open_start = '0;
		open_length = '0;
		after_match = 1'b0;
		merge_wait = cab_pkg::MERGE_NONE;
	endfunction

	// Works out the results that one accepted request causes.
	task automatic predict_blocks(input cab_pkg::cigar_op_t op);
		logic [31:0] len32;
		logic        failed;
		logic [2:0]  fault;
		len32 = {4'd0, op.op_length};
		failed = 1'b0;
		fault = cab_pkg::ST_BLOCK;
		if (op.first_op) begin
			abandon_read();
			skipping_read = 1'b0;
			ref_cursor = op.read_start;
		end
		if (skipping_read) begin
			return;
		end
		live_ops++;
		if (merge_wait != cab_pkg::MERGE_NONE) begin
			if (op.op_code == cab_pkg::OP_MATCH) begin
				ref_cursor = ref_cursor + len32;
				open_length = ref_cursor - open_start;
				merge_wait = cab_pkg::MERGE_NONE;
				after_match = 1'b1;
			end else begin
				failed = 1'b1;
				fault = (merge_wait == cab_pkg::MERGE_DEL) ? cab_pkg::ST_BAD_DEL
					: cab_pkg::ST_BAD_INS;
			end
		end else begin
			case (op.op_code)
				cab_pkg::OP_MATCH, cab_pkg::OP_SKIP: begin
					if (open_valid) begin
						expect_block(open_kind, open_start, open_length, cab_pkg::ST_BLOCK,
							1'b0);
					end
					open_valid = 1'b1;
					open_kind = (op.op_code == cab_pkg::OP_SKIP) ? KIND_INTRON : KIND_EXON;
					open_start = ref_cursor;
					open_length = len32;
					ref_cursor = ref_cursor + len32;
					after_match = (op.op_code == cab_pkg::OP_MATCH);
				end
				cab_pkg::OP_INS, cab_pkg::OP_DEL: begin
					if (!after_match || op.last_op) begin
						failed = 1'b1;
						fault = (op.op_code == cab_pkg::OP_DEL) ? cab_pkg::ST_BAD_DEL
							: cab_pkg::ST_BAD_INS;
					end else begin
						if (op.op_code == cab_pkg::OP_DEL) begin
							ref_cursor = ref_cursor + len32;
						end
						merge_wait = (op.op_code == cab_pkg::OP_DEL) ? cab_pkg::MERGE_DEL
							: cab_pkg::MERGE_INS;
						after_match = 1'b0;
					end
				end
				cab_pkg::OP_SOFT: begin
					after_match = 1'b0;
				end
				default: begin
					failed = 1'b1;
					fault = cab_pkg::ST_UNKNOWN;
				end
			endcase
		end
		if (failed) begin
			if (open_valid) begin
				expect_block(open_kind, open_start, open_length, cab_pkg::ST_BLOCK, 1'b0);
			end
			expect_block(KIND_EXON, '0, '0, fault, 1'b1);
			abandon_read();
			skipping_read = 1'b1;
		end else if (op.last_op) begin
			if (open_valid) begin
				expect_block(open_kind, open_start, open_length, cab_pkg::ST_BLOCK, 1'b1);
			end else begin
				expect_block(KIND_EXON, '0, '0, cab_pkg::ST_NOBLOCK, 1'b1);
			end
			abandon_read();
		end
	endtask

	// The valid is left high after a request; it drops only when a gap follows.
	task automatic send_op(input cab_pkg::cigar_op_t op);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			cig_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		cig <= op;
		cig_valid <= 1'b1;
		do @(posedge clk); while (cig_stall);
		predict_blocks(op);
	endtask

	always @(posedge clk) begin
		cab_pkg::block_t want;
		if (arst_n && blk_valid && !blk_stall) begin
			if (pending_blocks.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", blk));
			end else begin
				want = pending_blocks.pop_front();
				check_field("block_kind", 32'(blk.block_kind), 32'(want.block_kind));
				check_field("block_start", blk.block_start, want.block_start);
				check_field("block_length", blk.block_length, want.block_length);
				check_field("status", 32'(blk.status), 32'(want.status));
				check_field("last_of_read", 32'(blk.last_of_read), 32'(want.last_of_read));
			end
		end
		blk_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic cab_pkg::cigar_op_t mk_op(input logic [3:0] code,
		input logic [27:0] len, input logic [31:0] start, input logic first,
		input logic last);
		cab_pkg::cigar_op_t op;
		op.op_code = code;
		op.op_length = len;
		op.read_start = start;
		op.first_op = first;
		op.last_op = last;
		return op;
	endfunction

	function automatic logic [27:0] rand_length();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return r[27:0];
			default: return 28'($urandom_range(1, 300));
		endcase
	endfunction

	function automatic logic [31:0] rand_start();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 32'hFFFF_FFFF - $urandom_range(0, 500);
			default: return $urandom;
		endcase
	endfunction

	// A read built from matches, skips and merged indels with optional soft clips.
	task automatic send_clean_read();
		cab_pkg::cigar_op_t ops[$];
		cab_pkg::cigar_op_t op;
		int                 n_seg;
		logic               tail_match;
		n_seg = $urandom_range(1, 4);
		tail_match = 1'b0;
		if ($urandom_range(3) == 0) begin
			ops = {ops, mk_op(cab_pkg::OP_SOFT, rand_length(), '0, 1'b0, 1'b0)};
		end
		for (int s = 0; s < n_seg; s++) begin
			if (tail_match && $urandom_range(2) == 0) begin
				ops = {ops, mk_op($urandom_range(1) ? cab_pkg::OP_DEL : cab_pkg::OP_INS,
					rand_length(), '0, 1'b0, 1'b0)};
				ops = {ops, mk_op(cab_pkg::OP_MATCH, rand_length(), '0, 1'b0, 1'b0)};
			end else if ($urandom_range(2) == 0) begin
				ops = {ops, mk_op(cab_pkg::OP_SKIP, rand_length(), '0, 1'b0, 1'b0)};
				tail_match = 1'b0;
			end else begin
				ops = {ops, mk_op(cab_pkg::OP_MATCH, rand_length(), '0, 1'b0, 1'b0)};
				tail_match = 1'b1;
			end
		end
		if ($urandom_range(3) == 0) begin
			ops = {ops, mk_op(cab_pkg::OP_SOFT, rand_length(), '0, 1'b0, 1'b0)};
		end
		for (int i = 0; i < ops.size(); i++) begin
			op = ops[i];
			op.read_start = rand_start();
			// Now and then a read carries on at the running offset without a first op.
			op.first_op = (i == 0) && ($urandom_range(9) != 0);
			op.last_op = (i == ops.size() - 1);
			send_op(op);
		end
	endtask

	task automatic send_noisy_read();
		int          n_ops;
		logic [3:0]  code;
		logic        first;
		n_ops = $urandom_range(1, 5);
		for (int i = 0; i < n_ops; i++) begin
			code = 4'($urandom_range(1) ? $urandom_range(4) : $urandom_range(15));
			first = (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(9) == 0);
			send_op(mk_op(code, rand_length(), rand_start(), first, $urandom_range(4) == 0));
		end
	endtask

	task automatic run_reads(input int target);
		int start_count;
		start_count = live_ops;
		while (live_ops - start_count < target) begin
			if ($urandom_range(3) == 0) begin
				send_noisy_read();
			end else begin
				send_clean_read();
			end
		end
	endtask

	task automatic test_directed_cases();
		idle_pct = 0;
		stall_pct = 0;
		// Deletion merged into a match, then a skip, a soft clip and a zero-length match.
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd5, 32'd100, 1'b1, 1'b0));
		send_op(mk_op(cab_pkg::OP_DEL, 28'd3, '0, 1'b0, 1'b0));
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd7, '0, 1'b0, 1'b0));
		send_op(mk_op(cab_pkg::OP_SKIP, 28'd100, '0, 1'b0, 1'b0));
		send_op(mk_op(cab_pkg::OP_SOFT, 28'd2, '0, 1'b0, 1'b0));
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd0, '0, 1'b0, 1'b1));
		// Longest ops with an insertion merge, wrapping past the top of the reference.
		send_op(mk_op(cab_pkg::OP_MATCH, '1, 32'hFFFF_FFF0, 1'b1, 1'b0));
		send_op(mk_op(cab_pkg::OP_INS, '1, '1, 1'b0, 1'b0));
		send_op(mk_op(cab_pkg::OP_MATCH, '1, '0, 1'b0, 1'b1));
		// An op after a clean end with no first op continues at the running offset.
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd4, '0, 1'b0, 1'b1));
		// A read of only a soft clip ends without a block.
		send_op(mk_op(cab_pkg::OP_SOFT, 28'd1, 32'd7, 1'b1, 1'b1));
		// A deletion with no match before it; the rest of the read is dropped.
		send_op(mk_op(cab_pkg::OP_DEL, 28'd2, 32'd50, 1'b1, 1'b0));
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd3, '0, 1'b0, 1'b0));
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd1, '0, 1'b0, 1'b1));
		// An insertion as the last op flushes the held block before the error.
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd9, 32'd1000, 1'b1, 1'b0));
		send_op(mk_op(cab_pkg::OP_INS, 28'd2, '0, 1'b0, 1'b1));
		// A pending deletion or insertion followed by something other than a match.
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd9, 32'd2000, 1'b1, 1'b0));
		send_op(mk_op(cab_pkg::OP_DEL, 28'd1, '0, 1'b0, 1'b0));
		send_op(mk_op(cab_pkg::OP_SKIP, 28'd4, '0, 1'b0, 1'b0));
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd9, 32'd3000, 1'b1, 1'b0));
		send_op(mk_op(cab_pkg::OP_INS, 28'd1, '0, 1'b0, 1'b0));
		send_op(mk_op(cab_pkg::OP_SOFT, 28'd1, '0, 1'b0, 1'b1));
		// A first op abandons the held block of an unfinished read without output.
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd2, 32'd4000, 1'b1, 1'b0));
		send_op(mk_op(cab_pkg::OP_SKIP, 28'd3, '0, 1'b0, 1'b0));
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd1, 32'd5000, 1'b1, 1'b1));
		// Unknown ops, with and without a held block.
		send_op(mk_op(cab_pkg::OP_MATCH, 28'd1, 32'd6000, 1'b1, 1'b0));
		send_op(mk_op(OP_UNKNOWN_HI, 28'd0, '0, 1'b0, 1'b1));
		send_op(mk_op(OP_UNKNOWN_LO, 28'd0, 32'd7000, 1'b1, 1'b1));
	endtask

	task automatic test_full_rate();
		idle_pct = 0;
		stall_pct = 0;
		run_reads(150);
	endtask

	task automatic test_sparse_requests();
		idle_pct = 85;
		stall_pct = 0;
		run_reads(150);
	endtask

	task automatic test_result_backpressure();
		idle_pct = 0;
		stall_pct = 85;
		run_reads(150);
	endtask

	task automatic test_mixed_idling();
		idle_pct = 25;
		stall_pct = 25;
		run_reads(150);
	endtask

	initial begin
		ref_cursor = '0;
		skipping_read = 1'b0;
		abandon_read();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_full_rate();
		test_sparse_requests();
		test_result_backpressure();
		test_mixed_idling();
		cig_valid <= 1'b0;
		stall_pct = 0;
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/cab_pkg.sv
design/cab_front.sv
design/cab_queue.sv
design/cab_back.sv
design/cigar_to_aligned_blocks.sv
verif/tb.sv
